// ===== rtl/core/psg_pkg.sv =====
// psg_pkg: shared widths, datapath op codes, job codes and the command and
// status structs that join the polyline geometry controller and datapath.
// No dependencies.
package psg_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int POS_W     = 32;   // coordinate width
	localparam int DIFF_W    = 33;   // coordinate difference
	localparam int LEN_W     = 34;   // floor(sqrt) of a squared length
	localparam int PROD_W    = 68;   // multiplier product / accumulator
	localparam int DEN_W     = 102;  // a*b*c
	localparam int QUO_W     = 33;   // quotient bits developed by the divider
	localparam int SQR_W     = 36;   // square root partial remainder
	localparam int ARC_W     = 48;
	localparam int TAN_W     = 16;
	localparam int TAN_SHIFT = 14;
	localparam int KAP_W     = 32;
	localparam int TINY_W    = 16;
	localparam int CNT_W     = 6;
	localparam int PS_W      = 2;

	localparam logic signed [TAN_W-1:0] TAN_ONE = 16'sd16384;

	localparam logic [PS_W-1:0] PS_NONE = 2'd0;
	localparam logic [PS_W-1:0] PS_ONE  = 2'd1;
	localparam logic [PS_W-1:0] PS_TWO  = 2'd2;

	typedef enum logic [4:0] {
		DP_NOP, DP_LOAD, DP_START, DP_SQ0, DP_SQ1, DP_RINIT, DP_ROOT, DP_RSTORE,
		DP_CR0, DP_CR1, DP_DEN0, DP_DEN1, DP_DEN2, DP_DINIT, DP_DRUN, DP_DSTORE,
		DP_EMIT, DP_FINISH
	} dp_op_t;

	typedef enum logic [3:0] {
		J_LEN_B, J_LEN_A, J_LEN_C, J_KAP, J_T1X, J_T1Y, J_EMIT1,
		J_T2X, J_T2Y, J_EMIT2, J_FINISH, J_LONE
	} job_t;

	// difference vector selector: new-held, new-older, held-older
	typedef enum logic [1:0] {VEC_NH, VEC_NO, VEC_HO} vec_t;

	typedef struct packed {
		dp_op_t op;
		job_t   job;
		vec_t   vec;
	} cmd_t;

	typedef struct packed {
		logic [PS_W-1:0] ps;
		logic            last;
		logic            out_full;
	} status_t;

	function automatic logic signed [DIFF_W-1:0] diff(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		diff = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
	endfunction

	function automatic logic [LEN_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
		logic [DIFF_W-1:0] m;
		m = d[DIFF_W-1] ? (~d + 1'b1) : d;
		mag = LEN_W'(m);
	endfunction

endpackage

// ===== rtl/core/psg_ctrl.sv =====
// psg_ctrl: sequencer for one path point. Walks the job list (lengths,
// curvature, tangents, emits) and drives the datapath by commands.
// Depends on psg_pkg.
module psg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  psg_pkg::status_t status,
	output psg_pkg::cmd_t    cmd
);
	import psg_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_DECIDE = 17'h00002,
		S_SQ0    = 17'h00004,
		S_SQ1    = 17'h00008,
		S_RINIT  = 17'h00010,
		S_ROOT   = 17'h00020,
		S_RSTORE = 17'h00040,
		S_CR0    = 17'h00080,
		S_CR1    = 17'h00100,
		S_DEN0   = 17'h00200,
		S_DEN1   = 17'h00400,
		S_DEN2   = 17'h00800,
		S_DINIT  = 17'h01000,
		S_DRUN   = 17'h02000,
		S_DSTORE = 17'h04000,
		S_EMIT   = 17'h08000,
		S_FINISH = 17'h10000
	} state_t;

	state_t            state_q, state_d;
	job_t              job_q, job_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	function automatic job_t next_job(input job_t j, input logic [PS_W-1:0] ps,
		input logic last);
		case (j)
			J_LEN_B: next_job = (ps == PS_TWO) ? J_LEN_A : J_T1X;
			J_LEN_A: next_job = J_LEN_C;
			J_LEN_C: next_job = J_KAP;
			J_KAP:   next_job = J_T1X;
			J_T1X:   next_job = J_T1Y;
			J_T1Y:   next_job = J_EMIT1;
			J_EMIT1: next_job = last ? J_T2X : J_FINISH;
			J_T2X:   next_job = J_T2Y;
			J_T2Y:   next_job = J_EMIT2;
			default: next_job = J_FINISH;
		endcase
	endfunction

	function automatic state_t entry(input job_t j);
		case (j)
			J_LEN_B, J_LEN_A, J_LEN_C: entry = S_SQ0;
			J_KAP:                     entry = S_CR0;
			J_T1X, J_T1Y, J_T2X, J_T2Y: entry = S_DINIT;
			J_EMIT1, J_EMIT2, J_LONE:  entry = S_EMIT;
			default:                   entry = S_FINISH;
		endcase
	endfunction

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		cnt_d   = cnt_q;
		cmd.op  = DP_NOP;
		cmd.job = job_q;
		case (job_q)
			J_LEN_A:      cmd.vec = VEC_HO;
			J_LEN_C:      cmd.vec = VEC_NO;
			J_T1X, J_T1Y: cmd.vec = (status.ps == PS_TWO) ? VEC_NO : VEC_NH;
			default:      cmd.vec = VEC_NH;
		endcase
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (status.ps == PS_NONE) begin
					if (status.last) begin
						job_d   = J_LONE;
						state_d = S_EMIT;
					end else begin
						cmd.op  = DP_START;
						state_d = S_IDLE;
					end
				end else begin
					job_d   = J_LEN_B;
					state_d = S_SQ0;
				end
			end
			S_SQ0: begin
				cmd.op  = DP_SQ0;
				state_d = S_SQ1;
			end
			S_SQ1: begin
				cmd.op  = DP_SQ1;
				state_d = S_RINIT;
			end
			S_RINIT: begin
				cmd.op  = DP_RINIT;
				cnt_d   = CNT_W'(LEN_W - 1);
				state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.op = DP_ROOT;
				cnt_d  = cnt_q - 1'b1;
				if (cnt_q == '0) state_d = S_RSTORE;
			end
			S_RSTORE: begin
				cmd.op  = DP_RSTORE;
				job_d   = next_job(job_q, status.ps, status.last);
				state_d = entry(job_d);
			end
			S_CR0: begin
				cmd.op  = DP_CR0;
				state_d = S_CR1;
			end
			S_CR1: begin
				cmd.op  = DP_CR1;
				state_d = S_DEN0;
			end
			S_DEN0: begin
				cmd.op  = DP_DEN0;
				state_d = S_DEN1;
			end
			S_DEN1: begin
				cmd.op  = DP_DEN1;
				state_d = S_DEN2;
			end
			S_DEN2: begin
				cmd.op  = DP_DEN2;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.op  = DP_DINIT;
				cnt_d   = CNT_W'(QUO_W - 1);
				state_d = S_DRUN;
			end
			S_DRUN: begin
				cmd.op = DP_DRUN;
				cnt_d  = cnt_q - 1'b1;
				if (cnt_q == '0) state_d = S_DSTORE;
			end
			S_DSTORE: begin
				cmd.op  = DP_DSTORE;
				job_d   = next_job(job_q, status.ps, status.last);
				state_d = entry(job_d);
			end
			S_EMIT: begin
				if (!status.out_full) begin
					cmd.op = DP_EMIT;
					if (job_q == J_LONE) begin
						state_d = S_IDLE;
					end else begin
						job_d   = next_job(job_q, status.ps, status.last);
						state_d = entry(job_d);
					end
				end
			end
			S_FINISH: begin
				cmd.op  = DP_FINISH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= J_LEN_B;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/core/psg_datapath.sv =====
// psg_datapath: point window, running arc length, shared 34x34 multiplier,
// bit-serial square root and restoring divider, output register.
// Depends on psg_pkg.
module psg_datapath #(
	parameter int FRAC_BITS = psg_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psg_pkg::cmd_t                       cmd,
	output psg_pkg::status_t                    status,
	input  logic [psg_pkg::POS_W-1:0]           in_x,
	input  logic [psg_pkg::POS_W-1:0]           in_y,
	input  logic                                in_last,
	input  logic                                cfg_we,
	input  logic [psg_pkg::TINY_W-1:0]          cfg_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [psg_pkg::ARC_W-1:0]           out_arc,
	output logic signed [psg_pkg::TAN_W-1:0]    out_tx,
	output logic signed [psg_pkg::TAN_W-1:0]    out_ty,
	output logic signed [psg_pkg::KAP_W-1:0]    out_kap,
	output logic                                out_final
);
	import psg_pkg::*;

	localparam int KSH   = 2 * FRAC_BITS + 1;
	localparam int NUM_W = PROD_W - 2 + KSH;  // |cross| < 2^66
	localparam int REM_W = DEN_W + 1;

	logic [POS_W-1:0]         nx_q, ny_q, hx_q, hy_q, ox_q, oy_q;
	logic                     last_q;
	logic [PS_W-1:0]          ps_q;
	logic [ARC_W-1:0]         held_arc_q;
	logic [TINY_W-1:0]        tiny_q;
	logic [LEN_W-1:0]         len_a_q, len_b_q, len_c_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [DEN_W-1:0]         den_q, dvs_q;
	logic [LEN_W-1:0]         abhi_q;
	logic [PROD_W-1:0]        sqv_q;
	logic [SQR_W-1:0]         srem_q;
	logic [LEN_W-1:0]         root_q;
	logic [REM_W-1:0]         rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic                     dsat_q, kneg_q;
	logic signed [TAN_W-1:0]  tx_q, ty_q;
	logic signed [KAP_W-1:0]  kap_q;
	logic                     out_full_q;

	logic signed [DIFF_W-1:0] dnh_x, dnh_y, dno_x, dno_y, dho_x, dho_y, ux, uy, uc;
	logic [LEN_W-1:0]         len_v, mul_a, mul_b;
	logic [PROD_W-1:0]        prod, cr_mag;
	logic signed [PROD_W-1:0] prod_sgn;
	logic                     sgn, is_x, cr_neg, tan_job, t_ok, k_ok, k_sat, ge_root, ge_div;
	logic [NUM_W-1:0]         num;
	logic [NUM_W-QUO_W-1:0]   num_up;
	logic [DEN_W-1:0]         dvs_new;
	logic [SQR_W-1:0]         remn, trial;
	logic [REM_W-1:0]         rem_sh;
	logic [QUO_W-1:0]         k_lim, k_val;
	logic [TAN_W-1:0]         t_mag;
	logic [ARC_W:0]           arc_sum;
	logic [ARC_W-1:0]         arc_new;

	assign dnh_x = diff(nx_q, hx_q);
	assign dnh_y = diff(ny_q, hy_q);
	assign dno_x = diff(nx_q, ox_q);
	assign dno_y = diff(ny_q, oy_q);
	assign dho_x = diff(hx_q, ox_q);
	assign dho_y = diff(hy_q, oy_q);

	always_comb begin
		case (cmd.vec)
			VEC_NO: begin
				ux = dno_x; uy = dno_y; len_v = len_c_q;
			end
			VEC_HO: begin
				ux = dho_x; uy = dho_y; len_v = len_a_q;
			end
			default: begin
				ux = dnh_x; uy = dnh_y; len_v = len_b_q;
			end
		endcase
	end

	assign is_x    = (cmd.job == J_T1X) || (cmd.job == J_T2X);
	assign tan_job = (cmd.job != J_KAP);
	assign uc      = is_x ? ux : uy;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sgn   = 1'b0;
		case (cmd.op)
			DP_SQ0: begin
				mul_a = mag(ux); mul_b = mag(ux);
			end
			DP_SQ1: begin
				mul_a = mag(uy); mul_b = mag(uy);
			end
			DP_CR0: begin
				mul_a = mag(dho_x); mul_b = mag(dno_y);
				sgn   = dho_x[DIFF_W-1] ^ dno_y[DIFF_W-1];
			end
			DP_CR1: begin
				mul_a = mag(dho_y); mul_b = mag(dno_x);
				sgn   = dho_y[DIFF_W-1] ^ dno_x[DIFF_W-1];
			end
			DP_DEN0: begin
				mul_a = len_a_q; mul_b = len_b_q;
			end
			DP_DEN1: begin
				mul_a = den_q[LEN_W-1:0]; mul_b = len_c_q;
			end
			DP_DEN2: begin
				mul_a = abhi_q; mul_b = len_c_q;
			end
			default: begin
				mul_a = '0; mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_sgn = sgn ? -$signed(prod) : $signed(prod);

	assign cr_neg = acc_q[PROD_W-1];
	assign cr_mag = cr_neg ? PROD_W'(-acc_q) : PROD_W'(acc_q);

	// divider setup
	assign num     = tan_job ? (NUM_W'(mag(uc)) << TAN_SHIFT) : (NUM_W'(cr_mag) << KSH);
	assign num_up  = num[NUM_W-1:QUO_W];
	assign dvs_new = tan_job ? DEN_W'(len_v) : den_q;
	assign rem_sh  = {rem_q[REM_W-2:0], quo_q[QUO_W-1]};
	assign ge_div  = rem_sh >= {1'b0, dvs_q};

	// square root step
	assign remn    = {srem_q[SQR_W-3:0], sqv_q[PROD_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign ge_root = remn >= trial;

	// result shaping
	assign t_ok  = len_v > LEN_W'(tiny_q);
	assign t_mag = TAN_W'(quo_q);
	assign k_ok  = (len_a_q > LEN_W'(tiny_q)) && (len_b_q > LEN_W'(tiny_q))
		&& (len_c_q > LEN_W'(tiny_q));
	assign k_lim = kneg_q ? QUO_W'(33'h080000000) : QUO_W'(33'h07FFFFFFF);
	assign k_sat = dsat_q || (quo_q > k_lim);
	assign k_val = k_sat ? k_lim : quo_q;

	assign arc_sum = {1'b0, held_arc_q} + (ARC_W+1)'(len_b_q);
	assign arc_new = arc_sum[ARC_W] ? {ARC_W{1'b1}} : arc_sum[ARC_W-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q       <= PS_NONE;
			tiny_q     <= TINY_W'(1);
			out_full_q <= 1'b0;
		end else begin
			if (cfg_we) tiny_q <= cfg_data;
			if (cmd.op == DP_START) ps_q <= PS_ONE;
			if (cmd.op == DP_FINISH) ps_q <= last_q ? PS_NONE : PS_TWO;
			if (cmd.op == DP_EMIT) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				nx_q   <= in_x;
				ny_q   <= in_y;
				last_q <= in_last;
				kap_q  <= '0;
			end
			DP_START: begin
				hx_q       <= nx_q;
				hy_q       <= ny_q;
				held_arc_q <= '0;
			end
			DP_SQ0: acc_q <= $signed(prod);
			DP_SQ1: acc_q <= acc_q + $signed(prod);
			DP_CR0: acc_q <= prod_sgn;
			DP_CR1: acc_q <= acc_q - prod_sgn;
			DP_RINIT: begin
				sqv_q  <= acc_q;
				srem_q <= '0;
				root_q <= '0;
			end
			DP_ROOT: begin
				srem_q <= ge_root ? (remn - trial) : remn;
				root_q <= {root_q[LEN_W-2:0], ge_root};
				sqv_q  <= sqv_q << 2;
			end
			DP_RSTORE: begin
				case (cmd.job)
					J_LEN_A: len_a_q <= root_q;
					J_LEN_C: len_c_q <= root_q;
					default: len_b_q <= root_q;
				endcase
			end
			DP_DEN0: den_q <= DEN_W'(prod);
			DP_DEN1: begin
				abhi_q <= den_q[2*LEN_W-1:LEN_W];
				den_q  <= DEN_W'(prod);
			end
			DP_DEN2: den_q <= den_q + (DEN_W'(prod) << LEN_W);
			DP_DINIT: begin
				quo_q  <= num[QUO_W-1:0];
				rem_q  <= REM_W'(num_up);
				dvs_q  <= dvs_new;
				dsat_q <= REM_W'(num_up) >= REM_W'(dvs_new);
				kneg_q <= cr_neg;
			end
			DP_DRUN: begin
				rem_q <= ge_div ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
				quo_q <= {quo_q[QUO_W-2:0], ge_div};
			end
			DP_DSTORE: begin
				case (cmd.job)
					J_KAP: kap_q <= k_ok ? $signed(KAP_W'(kneg_q ? (~k_val + 1'b1) : k_val))
						: '0;
					J_T1X, J_T2X: tx_q <= !t_ok ? '0 : (uc[DIFF_W-1] ? -$signed(t_mag)
						: $signed(t_mag));
					default: ty_q <= !t_ok ? '0 : (uc[DIFF_W-1] ? -$signed(t_mag)
						: $signed(t_mag));
				endcase
			end
			DP_EMIT: begin
				case (cmd.job)
					J_LONE: begin
						out_arc <= '0; out_tx <= TAN_ONE; out_ty <= '0;
						out_kap <= '0; out_final <= 1'b1;
					end
					J_EMIT1: begin
						out_arc <= held_arc_q; out_tx <= tx_q; out_ty <= ty_q;
						out_kap <= kap_q; out_final <= 1'b0;
						held_arc_q <= arc_new;
					end
					default: begin
						out_arc <= held_arc_q; out_tx <= tx_q; out_ty <= ty_q;
						out_kap <= '0; out_final <= 1'b1;
					end
				endcase
			end
			DP_FINISH: begin
				if (last_q) begin
					held_arc_q <= '0;
				end else begin
					ox_q <= hx_q;
					oy_q <= hy_q;
					hx_q <= nx_q;
					hy_q <= ny_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_full_q;
	assign status.ps       = ps_q;
	assign status.last     = last_q;
	assign status.out_full = out_full_q;

endmodule

// ===== rtl/core/polyline_sample_geometry.sv =====
// polyline_sample_geometry: top level. Per-point arc length, unit tangent and
// three-point curvature of a streamed 2-D path. Uses psg_pkg, psg_ctrl and
// psg_datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: pos_x, pos_y; tlast: end_of_path
//  m_*     | out | m_tvalid/m_tready  | tdata: arc_length, tangent_x, tangent_y,
//          |     |                    |   curvature; tlast: final_result
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: tiny_distance
//
// One point at a time. An interior point runs three 34-step square roots, one
// 33-step curvature division and two 33-step tangent divisions, one after
// another on the bit-per-cycle square root and divider. The second point of a
// path runs one square root and two tangent divisions, a final point adds two
// more tangent divisions and a second emit, a lone point only emits and a
// first point is only held.
// Reset clears the window (no points held) and sets tiny_distance to 1.
// A result waits in the output register while m_tready is low; the next
// point is taken and worked on meanwhile, stalling only at its own emit.
module polyline_sample_geometry #(
	parameter int FRAC_BITS = psg_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [63:0]   s_tdata,   // [31:0] pos_x, [63:32] pos_y
	input  logic          s_tlast,   // end_of_path
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // [47:0] arc_length, [63:48] tangent_x,
	                                 // [79:64] tangent_y, [111:80] curvature
	output logic          m_tlast,   // final_result
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data   // tiny_distance
);
	import psg_pkg::*;

	cmd_t                    cmd;
	status_t                 status;
	logic [ARC_W-1:0]        out_arc;
	logic signed [TAN_W-1:0] out_tx, out_ty;
	logic signed [KAP_W-1:0] out_kap;

	// register write is always taken; the user must write it only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	psg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	psg_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_x      (s_tdata[31:0]),
		.in_y      (s_tdata[63:32]),
		.in_last   (s_tlast),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_arc   (out_arc),
		.out_tx    (out_tx),
		.out_ty    (out_ty),
		.out_kap   (out_kap),
		.out_final (m_tlast)
	);

	assign m_tdata = {out_kap, out_ty, out_tx, out_arc};

endmodule

// ===== rtl/core/psg_checker.sv =====
// psg_checker: port-level checks for polyline_sample_geometry, attached by
// bind. Depends on nothing but the top level's ports.
module psg_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [63:0]  s_tdata,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata,
	input logic         m_tlast,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [15:0]  cfg_data
);

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// one point in flight: no input right after a transaction
	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a point is in work");

	// tangent_x stays within unit length
	a_tan_x: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[63:48]) >= -16'sd16384)
			&& ($signed(m_tdata[63:48]) <= 16'sd16384))
		else $error("tangent_x out of range");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind polyline_sample_geometry psg_checker u_psg_checker (.*);

// ===== test/polyline_sample_geometry_tb.sv =====
// polyline_sample_geometry_tb: self-checking bench for the polyline geometry
// block. Drives random and directed paths, predicts every result in-bench.
// Depends on psg_pkg and the RTL of polyline_sample_geometry.
`timescale 1ns / 100ps

module polyline_sample_geometry_tb;
	import psg_pkg::*;

	localparam int N_RANDOM = 600;
	localparam int WATCHDOG = 200000;
	localparam logic [47:0] ARC_SAT = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [47:0]        arc;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [31:0] kap;
		logic               fin;
	} geom_t;

	// directed stimulus row: point, flag, and optional typed-in expectation
	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        last;
		bit          has_exp;
		geom_t       exp;
	} point_row_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_valid = 0;
	logic [63:0] s_tdata = '0;
	logic [15:0] cfg_data = '0;
	logic s_tready, m_tvalid, m_tlast, cfg_ready;
	logic [111:0] m_tdata;

	// predictor state
	logic [15:0] tiny_q;
	logic signed [32:0] older_x, older_y, held_x, held_y;
	logic [47:0] held_arc;
	int points_held;

	geom_t pending_q[$];
	geom_t last_queued;
	int errors = 0, results_seen = 0, points_sent = 0, idle_cycles = 0;
	bit hold_sink = 0;

	polyline_sample_geometry DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic logic [33:0] isqrt(input logic [127:0] v);
		logic [33:0] r;
		logic [33:0] t;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			t = r | (34'd1 << b);
			if ({94'd0, t} * {94'd0, t} <= v) r = t;
		end
		return r;
	endfunction

	function automatic logic [33:0] seg_len(input logic signed [33:0] dx,
		input logic signed [33:0] dy);
		logic [127:0] ax, ay;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		return isqrt(ax * ax + ay * ay);
	endfunction

	function automatic void direction(input logic signed [33:0] dx,
		input logic signed [33:0] dy, output logic signed [15:0] tx,
		output logic signed [15:0] ty);
		logic [33:0] len;
		logic [63:0] qx, qy;
		len = seg_len(dx, dy);
		if (len <= tiny_q) begin
			tx = 0;
			ty = 0;
			return;
		end
		qx = ({30'd0, (dx < 0 ? -dx : dx)} << 14) / len;
		qy = ({30'd0, (dy < 0 ? -dy : dy)} << 14) / len;
		tx = dx < 0 ? -qx[15:0] : qx[15:0];
		ty = dy < 0 ? -qy[15:0] : qy[15:0];
	endfunction

	// signed Menger curvature through three points, saturating
	function automatic logic signed [31:0] bend(input logic signed [32:0] ox,
		input logic signed [32:0] oy, input logic signed [32:0] hx,
		input logic signed [32:0] hy, input logic signed [32:0] nx,
		input logic signed [32:0] ny);
		logic [33:0] a, b, c;
		logic signed [127:0] cr;
		logic [127:0] num, den, q;
		bit neg;
		a = seg_len(hx - ox, hy - oy);
		b = seg_len(nx - hx, ny - hy);
		c = seg_len(nx - ox, ny - oy);
		if (a <= tiny_q || b <= tiny_q || c <= tiny_q) return 0;
		cr = 128'(signed'(hx - ox)) * 128'(signed'(ny - oy))
			- 128'(signed'(hy - oy)) * 128'(signed'(nx - ox));
		neg = cr < 0;
		num = (neg ? -cr : cr) << 33;
		den = 128'(a) * 128'(b) * 128'(c);
		q = num / den;
		if (neg) return q > 128'h8000_0000 ? 32'sh8000_0000 : -q[31:0];
		return q > 128'h7FFF_FFFF ? 32'sh7FFF_FFFF : q[31:0];
	endfunction

	// append one expected result transaction
	function automatic void queue_result(input geom_t r);
		pending_q.insert(pending_q.size(), r);
		last_queued = r;
	endfunction

	// advance the path window by one point, queue the results it causes
	task automatic predict_point(input logic [31:0] px, input logic [31:0] py,
		input logic last);
		logic signed [32:0] nx, ny;
		logic [48:0] arc;
		geom_t r;
		nx = signed'(px);
		ny = signed'(py);
		if (points_held == 0) begin
			if (last) begin
				r = '{arc: '0, tx: TAN_ONE, ty: 0, kap: 0, fin: 1};
				queue_result(r);
			end else begin
				held_x = nx;
				held_y = ny;
				held_arc = '0;
				points_held = 1;
			end
			return;
		end
		r = '0;
		r.arc = held_arc;
		if (points_held == 1) direction(nx - held_x, ny - held_y, r.tx, r.ty);
		else begin
			direction(nx - older_x, ny - older_y, r.tx, r.ty);
			r.kap = bend(older_x, older_y, held_x, held_y, nx, ny);
		end
		queue_result(r);
		arc = {1'b0, held_arc} + seg_len(nx - held_x, ny - held_y);
		if (arc[48]) arc = {1'b0, ARC_SAT};
		if (last) begin
			r = '0;
			r.arc = arc[47:0];
			r.fin = 1;
			direction(nx - held_x, ny - held_y, r.tx, r.ty);
			queue_result(r);
			points_held = 0;
			held_arc = '0;
			return;
		end
		older_x = held_x;
		older_y = held_y;
		held_x = nx;
		held_y = ny;
		held_arc = arc[47:0];
		points_held = 2;
	endtask

	// result checker and sink-side stall generator
	always @(posedge clk) begin
		geom_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{arc: m_tdata[47:0], tx: m_tdata[63:48], ty: m_tdata[79:64],
				kap: m_tdata[111:80], fin: m_tlast};
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("unexpected result transaction arc=%0d", got.arc);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (got.arc !== want.arc) begin
					$error("arc_length exp %0d got %0d", want.arc, got.arc); errors++;
				end
				if (got.tx !== want.tx) begin
					$error("tangent_x exp %0d got %0d", want.tx, got.tx); errors++;
				end
				if (got.ty !== want.ty) begin
					$error("tangent_y exp %0d got %0d", want.ty, got.ty); errors++;
				end
				if (got.kap !== want.kap) begin
					$error("curvature exp %0d got %0d", want.kap, got.kap); errors++;
				end
				if (got.fin !== want.fin) begin
					$error("final_result exp %0d got %0d", want.fin, got.fin); errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		int roll;
		roll = $urandom_range(0, 99);
		if (hold_sink || roll < 60) m_tready <= 1;
		else if (roll < 97) m_tready <= 0;
		else begin
			m_tready <= 0;
			repeat ($urandom_range(20, 400)) @(negedge clk);
		end
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	// valid stays low for a random gap between points
	task automatic source_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) @(negedge clk);
		else if (roll < 95) repeat ($urandom_range(1, 4)) @(negedge clk);
		else repeat ($urandom_range(50, 800)) @(negedge clk);
	endtask

	// one input transaction; the predictor runs once it is accepted
	task automatic send_point(input logic [31:0] px, input logic [31:0] py,
		input logic last);
		s_tdata <= {py, px};
		s_tlast <= last;
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_point(px, py, last);
		points_sent++;
		@(negedge clk);
		s_tvalid <= 0;
		source_gap();
	endtask

	task automatic drain();
		hold_sink = 1;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);   // a first point that is not last emits nothing
		hold_sink = 0;
	endtask

	// only while idle: all results in, window state irrelevant for the write
	task automatic write_tiny(input logic [15:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tiny_q = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] rand_coord(input int span);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	task automatic run_random_path();
		int n, span, cx, cy;
		n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 12);
		span = $urandom_range(0, 3) == 0 ? 8 : (1 << $urandom_range(4, 24));
		cx = $urandom();
		cy = $urandom();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0)
				send_point(rand_coord(span), rand_coord(span), i == n - 1);
			else begin
				cx = cx + $urandom_range(0, 2 * span) - span;
				cy = cy + $urandom_range(0, 2 * span) - span;
				send_point(cx, cy, i == n - 1);
			end
		end
	endtask

	point_row_t rows[$];

	initial begin
		point_row_t pr;
		int lo_tiny_paths;
		tiny_q = 16'd1;
		points_held = 0;
		older_x = 0; older_y = 0; held_x = 0; held_y = 0; held_arc = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: lone point, extremes, short tangents, straight and turning
		rows = '{
			'{0, 0, 1, 1, '{0, TAN_ONE, 0, 0, 1}},
			'{32'h7FFF_FFFF, 32'h8000_0000, 1, 1, '{0, TAN_ONE, 0, 0, 1}},
			'{32'h8000_0000, 32'h8000_0000, 0, 0, '0},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, '0},
			'{32'h8000_0000, 32'h7FFF_FFFF, 0, 0, '0},
			'{32'h7FFF_FFFF, 32'h8000_0000, 1, 0, '0},
			'{0, 0, 0, 0, '0},
			'{1, 0, 0, 0, '0},
			'{1, 1, 0, 0, '0},
			'{1, 1, 1, 0, '0},
			'{0, 0, 0, 0, '0},
			'{32'h0001_0000, 0, 0, 0, '0},
			'{32'h0002_0000, 0, 0, 0, '0},
			'{32'h0002_0000, 32'h0001_0000, 0, 0, '0},
			'{32'h0001_0000, 32'h0001_0000, 0, 0, '0},
			'{32'h0001_0000, 32'h0001_0000, 1, 0, '0},
			'{5, 7, 0, 0, '0},
			'{5, 7, 1, 0, '0}
		};
		foreach (rows[i]) begin
			pr = rows[i];
			if (pr.has_exp) begin
				// typed-in expectation checked against the predictor
				send_point(pr.x, pr.y, pr.last);
				if (last_queued !== pr.exp) begin
					$error("directed row %0d expectation disagrees", i);
					errors++;
				end
			end else send_point(pr.x, pr.y, pr.last);
		end

		write_tiny(16'hFFFF);
		for (int i = 0; i < 15; i++) run_random_path();
		write_tiny(16'h0000);
		for (int i = 0; i < 15; i++) run_random_path();
		write_tiny(16'd300);
		lo_tiny_paths = 0;
		while (points_sent < N_RANDOM) begin
			run_random_path();
			lo_tiny_paths++;
			if (lo_tiny_paths == 40) write_tiny(16'($urandom_range(0, 16'hFFFF)));
		end
		write_tiny(16'd1);
		for (int i = 0; i < 5; i++) run_random_path();

		drain();
		$display("Sent %0d points, checked %0d result transactions, tiny_distance 0..65535.",
			points_sent, results_seen);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/psg_pkg.sv
rtl/core/psg_ctrl.sv
rtl/core/psg_datapath.sv
rtl/core/polyline_sample_geometry.sv
rtl/core/psg_checker.sv
test/polyline_sample_geometry_tb.sv
